/* design/sit_pkg.sv */
// sorted index table: shared widths, command and status codes, controller states
// no dependencies
`timescale 1ns / 1ps

package sit_pkg;

	localparam int TABLE_SIZE_DEF = 32;
	localparam int KEY_W          = 31;
	localparam int CMD_W          = 2;
	localparam int STAT_W         = 2;
	localparam int SLOT_OUT_W     = 5;

	localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] RS_OK        = 2'd0;
	localparam logic [STAT_W-1:0] RS_NOT_FOUND = 2'd1;
	localparam logic [STAT_W-1:0] RS_DUPLICATE = 2'd2;
	localparam logic [STAT_W-1:0] RS_FULL      = 2'd3;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SEARCH,
		FSM_COMPARE,
		FSM_MARK,
		FSM_SHIFT,
		FSM_INSERT,
		FSM_DONE
	} sit_state_t;

endpackage

/* design/sit_req_if.sv */
// sorted index table: command channel, one item per command
// depends on sit_pkg
`timescale 1ns / 1ps

interface sit_req_if;
	import sit_pkg::*;

	logic                valid;
	logic                ready;
	logic [CMD_W-1:0]    command;
	logic [KEY_W-1:0]    search_key;

	modport source (output valid, command, search_key, input ready);
	modport sink   (input valid, command, search_key, output ready);
endinterface

/* design/sit_rsp_if.sv */
// sorted index table: result channel, one item per command
// depends on sit_pkg
`timescale 1ns / 1ps

interface sit_rsp_if;
	import sit_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [STAT_W-1:0]      result_status;
	logic [SLOT_OUT_W-1:0]  data_slot;
	logic                   slot_deleted;

	modport source (output valid, result_status, data_slot, slot_deleted, input ready);
	modport sink   (input valid, result_status, data_slot, slot_deleted, output ready);
endinterface

/* design/sorted_index_table.sv */
// sorted index table: lookup by binary search, insert with shift-up, logical delete
// depends on sit_pkg, sit_req_if, sit_rsp_if, sit_mem
// each search probe reads a key, then compares it; at most clog2(TABLE_SIZE+1) probes
// insert shifts the entries above its position up, one entry moved per cycle through the key port
// the next item is taken while a result waits
// reset clears the entry count and the controller; memories hold no reset value
`timescale 1ns / 1ps

module sorted_index_table #(
	parameter int TABLE_SIZE = sit_pkg::TABLE_SIZE_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sit_req_if.sink   req,
	sit_rsp_if.source rsp
);
	import sit_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int CNT_W   = $clog2(TABLE_SIZE + 1);
	localparam int ENTRY_W = KEY_W + IDX_W;

	sit_state_t state_q, state_d;

	logic [CMD_W-1:0]  cmd_q;
	logic [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]  cnt_q, lo_q, hi_q, mid_q, pos_q, idx_q, pdest_q;
	logic              pend_q;
	logic [IDX_W-1:0]  slot_q;
	logic [STAT_W-1:0] fin_status_q;
	logic [IDX_W-1:0]  fin_slot_q;
	logic              fin_mark_q;
	logic              res_valid_q;
	logic [STAT_W-1:0] res_status_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic              res_mark_q;

	logic [CNT_W-1:0]  mid;
	logic              search_go;
	logic              in_take;
	logic              res_load;
	logic [IDX_W+SLOT_OUT_W-1:0] slot_wide;

	logic               krd_en, kwr_en;
	logic [IDX_W-1:0]   krd_addr, kwr_addr;
	logic [ENTRY_W-1:0] kwr_data, krd_data;
	logic [KEY_W-1:0]   rd_key;
	logic [IDX_W-1:0]   rd_slot;

	logic               mrd_en, mwr_en;
	logic [IDX_W-1:0]   mrd_addr, mwr_addr;
	logic               mwr_data, mrd_data;

	sit_mem #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SIZE)) u_keys (
		.clk     (clk),
		.wr_en   (kwr_en),
		.wr_addr (kwr_addr),
		.wr_data (kwr_data),
		.rd_en   (krd_en),
		.rd_addr (krd_addr),
		.rd_data (krd_data)
	);

	sit_mem #(.WIDTH(1), .DEPTH(TABLE_SIZE)) u_marks (
		.clk     (clk),
		.wr_en   (mwr_en),
		.wr_addr (mwr_addr),
		.wr_data (mwr_data),
		.rd_en   (mrd_en),
		.rd_addr (mrd_addr),
		.rd_data (mrd_data)
	);

	assign rd_key    = krd_data[ENTRY_W-1:IDX_W];
	assign rd_slot   = krd_data[IDX_W-1:0];
	assign mid       = lo_q + ((hi_q - lo_q) >> 1);
	assign search_go = lo_q < hi_q;
	assign in_take   = req.valid && req.ready;
	assign res_load  = (state_q == FSM_DONE) && (!res_valid_q || rsp.ready);
	assign slot_wide = {{SLOT_OUT_W{1'b0}}, fin_slot_q};

	assign req.ready         = (state_q == FSM_IDLE);
	assign rsp.valid         = res_valid_q;
	assign rsp.result_status = res_status_q;
	assign rsp.data_slot     = res_slot_q;
	assign rsp.slot_deleted  = res_mark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		krd_en   = 1'b0;
		krd_addr = mid[IDX_W-1:0];
		kwr_en   = 1'b0;
		kwr_addr = pdest_q[IDX_W-1:0];
		kwr_data = krd_data;
		mrd_en   = 1'b0;
		mrd_addr = rd_slot;
		mwr_en   = 1'b0;
		mwr_addr = slot_q;
		mwr_data = 1'b1;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_take) begin
					state_d = FSM_SEARCH;
				end
			end
			FSM_SEARCH: begin
				if (search_go) begin
					krd_en  = 1'b1;
					state_d = FSM_COMPARE;
				end else if (cmd_q == CMD_INSERT && cnt_q != CNT_W'(TABLE_SIZE)) begin
					state_d = FSM_SHIFT;
				end else begin
					state_d = FSM_DONE;
				end
			end
			FSM_COMPARE: begin
				if (rd_key == key_q) begin
					mrd_en  = 1'b1;
					state_d = FSM_MARK;
				end else begin
					state_d = FSM_SEARCH;
				end
			end
			FSM_MARK: begin
				if (cmd_q == CMD_DELETE && !mrd_data) begin
					mwr_en = 1'b1;
				end
				state_d = FSM_DONE;
			end
			FSM_SHIFT: begin
				kwr_en = pend_q;
				if (idx_q > pos_q) begin
					krd_en   = 1'b1;
					krd_addr = idx_q[IDX_W-1:0] - IDX_W'(1);
				end else begin
					state_d = FSM_INSERT;
				end
			end
			FSM_INSERT: begin
				kwr_en   = 1'b1;
				kwr_addr = pos_q[IDX_W-1:0];
				kwr_data = {key_q, cnt_q[IDX_W-1:0]};
				mwr_en   = 1'b1;
				mwr_addr = cnt_q[IDX_W-1:0];
				mwr_data = 1'b0;
				state_d  = FSM_DONE;
			end
			FSM_DONE: begin
				if (res_load) begin
					state_d = FSM_IDLE;
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				pend_q <= 1'b0;
			end
			if (state_q == FSM_SHIFT) begin
				pend_q <= idx_q > pos_q;
			end
			if (state_q == FSM_INSERT) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			FSM_IDLE: begin
				cmd_q <= req.command;
				key_q <= req.search_key;
				lo_q  <= '0;
				hi_q  <= cnt_q;
			end
			FSM_SEARCH: begin
				mid_q <= mid;
				pos_q <= lo_q;
				idx_q <= cnt_q;
				if (!search_go) begin
					fin_mark_q <= 1'b0;
					if (cmd_q == CMD_INSERT && cnt_q != CNT_W'(TABLE_SIZE)) begin
						fin_status_q <= RS_OK;
						fin_slot_q   <= cnt_q[IDX_W-1:0];
					end else begin
						fin_status_q <= (cmd_q == CMD_INSERT) ? RS_FULL : RS_NOT_FOUND;
						fin_slot_q   <= '0;
					end
				end
			end
			FSM_COMPARE: begin
				slot_q <= rd_slot;
				if (rd_key != key_q) begin
					if (key_q > rd_key) begin
						lo_q <= mid_q + CNT_W'(1);
					end else begin
						hi_q <= mid_q;
					end
				end
			end
			FSM_MARK: begin
				priority if (cmd_q == CMD_INSERT) begin
					fin_status_q <= RS_DUPLICATE;
					fin_slot_q   <= slot_q;
					fin_mark_q   <= mrd_data;
				end else if (cmd_q == CMD_DELETE) begin
					if (mrd_data) begin
						fin_status_q <= RS_NOT_FOUND;
						fin_slot_q   <= '0;
						fin_mark_q   <= 1'b0;
					end else begin
						fin_status_q <= RS_OK;
						fin_slot_q   <= slot_q;
						fin_mark_q   <= 1'b1;
					end
				end else begin
					fin_status_q <= RS_OK;
					fin_slot_q   <= slot_q;
					fin_mark_q   <= mrd_data;
				end
			end
			FSM_SHIFT: begin
				if (idx_q > pos_q) begin
					pdest_q <= idx_q;
					idx_q   <= idx_q - CNT_W'(1);
				end
			end
			FSM_INSERT: begin
			end
			FSM_DONE: begin
				if (res_load) begin
					res_status_q <= fin_status_q;
					res_slot_q   <= slot_wide[SLOT_OUT_W-1:0];
					res_mark_q   <= fin_mark_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_SIZE))
		else $error("entry count beyond table size");

	a_key_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		kwr_en |-> (state_q == FSM_SHIFT || state_q == FSM_INSERT))
		else $error("key memory written outside shift or insert");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == FSM_INSERT |=> cnt_q == $past(cnt_q) + CNT_W'(1))
		else $error("insert did not advance entry count");

	a_take_starts_search: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q == FSM_SEARCH)
		else $error("accepted item did not start a search");

	a_full_empty_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_load && fin_status_q == RS_FULL |-> fin_slot_q == '0 && !fin_mark_q)
		else $error("full status with slot data");

endmodule

/* design/sit_mem.sv */
// sorted index table: simple dual-port memory, one write and one read port
// registered read data; no dependencies
`timescale 1ns / 1ps

module sit_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* tb/sv/sit_result_checker.sv */
// sorted index table checker: watches the command and result channels, predicts each result
// from its own copy of the index and compares it field by field
// depends on sit_pkg, sit_req_if, sit_rsp_if
`timescale 1ns / 1ps

module sit_result_checker #(
	parameter int TABLE_SIZE = sit_pkg::TABLE_SIZE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sit_req_if   req,
	sit_rsp_if   rsp,
	output int   mismatches,
	output int   pending,
	output int   checked,
	output int   ok_seen,
	output int   miss_seen,
	output int   dup_seen,
	output int   full_seen
);
	import sit_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0]     status;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  mark;
	} sit_result_t;

	logic [KEY_W-1:0] stored_keys [TABLE_SIZE];
	int               stored_slots [TABLE_SIZE];
	bit               slot_marks [TABLE_SIZE];
	int               used;

	sit_result_t awaited_results [$];
	int          miss_count;
	int          check_count;
	int          status_count [4];

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		miss_count++;
	endtask

	function automatic sit_result_t table_outcome(input logic [CMD_W-1:0] cmd,
			input logic [KEY_W-1:0] key);
		sit_result_t r;
		int lo;
		int hi;
		int mid;
		int pos;
		int s;
		bit hit;
		r.status = RS_NOT_FOUND;
		r.slot = '0;
		r.mark = 1'b0;
		lo = 0;
		hi = used;
		hit = 1'b0;
		pos = 0;
		while (lo < hi && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (stored_keys[mid] == key) begin
				hit = 1'b1;
				pos = mid;
			end else if (key > stored_keys[mid]) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		if (!hit)
			pos = lo;
		s = hit ? stored_slots[pos] % TABLE_SIZE : 0;
		case (cmd)
		CMD_INSERT: begin
			if (hit) begin
				r.status = RS_DUPLICATE;
				r.slot = s[SLOT_OUT_W-1:0];
				r.mark = slot_marks[s];
			end else if (used >= TABLE_SIZE) begin
				r.status = RS_FULL;
			end else begin
				s = used;
				for (int i = used; i > pos; i--) begin
					stored_keys[i] = stored_keys[i-1];
					stored_slots[i] = stored_slots[i-1];
				end
				stored_keys[pos] = key;
				stored_slots[pos] = s;
				slot_marks[s] = 1'b0;
				used++;
				r.status = RS_OK;
				r.slot = s[SLOT_OUT_W-1:0];
			end
		end
		CMD_DELETE: begin
			if (hit && !slot_marks[s]) begin
				slot_marks[s] = 1'b1;
				r.status = RS_OK;
				r.slot = s[SLOT_OUT_W-1:0];
				r.mark = 1'b1;
			end
		end
		default: begin
			// unused command code behaves as a lookup
			if (hit) begin
				r.status = RS_OK;
				r.slot = s[SLOT_OUT_W-1:0];
				r.mark = slot_marks[s];
			end
		end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sit_result_t want;
		if (!arst_n) begin
			used = 0;
			awaited_results.delete();
			miss_count = 0;
			check_count = 0;
			for (int i = 0; i < 4; i++)
				status_count[i] = 0;
		end else begin
			if (req.valid && req.ready)
				awaited_results.push_back(table_outcome(req.command, req.search_key));
			if (rsp.valid && rsp.ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("result item with nothing awaited", rsp.result_status, -1);
				end else begin
					want = awaited_results.pop_front();
					check_count++;
					if (rsp.result_status !== want.status)
						flag_mismatch("result_status", rsp.result_status, want.status);
					if (rsp.data_slot !== want.slot)
						flag_mismatch("data_slot", rsp.data_slot, want.slot);
					if (rsp.slot_deleted !== want.mark)
						flag_mismatch("slot_deleted", rsp.slot_deleted, want.mark);
					status_count[want.status]++;
				end
			end
		end
		mismatches <= miss_count;
		pending <= awaited_results.size();
		checked <= check_count;
		ok_seen <= status_count[RS_OK];
		miss_seen <= status_count[RS_NOT_FOUND];
		dup_seen <= status_count[RS_DUPLICATE];
		full_seen <= status_count[RS_FULL];
	end

endmodule

/* tb/sv/tb_sorted_index_table.sv */
// sorted index table testbench top: clock, reset, command stimulus, result back-pressure
// and the verdict; checking is left to sit_result_checker
// depends on sit_pkg, sit_req_if, sit_rsp_if, sorted_index_table, sit_result_checker
`timescale 1ns / 1ps

module tb_sorted_index_table;
	import sit_pkg::*;

	localparam int TABLE_SIZE = TABLE_SIZE_DEF;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int POOL_SIZE = 48;
	localparam int PHASE_ITEMS = 230;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 5000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sit_req_if req_ch ();
	sit_rsp_if rsp_ch ();

	int mismatches;
	int pending;
	int checked;
	int ok_seen;
	int miss_seen;
	int dup_seen;
	int full_seen;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_asked;
	int hold_served;
	int hold_left;
	int sent;
	int quiet_cycles;

	sorted_index_table #(.TABLE_SIZE(TABLE_SIZE)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sit_result_checker #(.TABLE_SIZE(TABLE_SIZE)) scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.ok_seen    (ok_seen),
		.miss_seen  (miss_seen),
		.dup_seen   (dup_seen),
		.full_seen  (full_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result back-pressure, with a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_served = 0;
			hold_left = 0;
		end else begin
			if (hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
				$display("sorted_index_table: mismatch");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < tx_idle_pct)
				@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.command <= cmd;
		req_ch.search_key <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic random_phase(input logic [KEY_W-1:0] pool [POOL_SIZE]);
		int roll;
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 40)
				cmd = CMD_LOOKUP;
			else if (roll < 70)
				cmd = CMD_INSERT;
			else if (roll < 95)
				cmd = CMD_DELETE;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(0, 99) < 85)
				key = pool[$urandom_range(0, POOL_SIZE - 1)];
			else
				key = KEY_W'($urandom());
			send_item(cmd, key);
		end
	endtask

	initial begin
		logic [KEY_W-1:0] pool [POOL_SIZE];
		quiet_cycles = 0;
		sent = 0;
		tx_idle_pct = 19;
		req_ch.valid <= 1'b0;
		req_ch.command <= CMD_LOOKUP;
		req_ch.search_key <= '0;
		rx_idle_pct <= 57;
		hold_asked <= 0;
		pool[0] = 31'd1;
		pool[1] = 31'h7FFF_FFFF;
		pool[2] = 31'd0;
		pool[3] = 31'h4000_0000;
		for (int i = 4; i < POOL_SIZE; i++)
			pool[i] = KEY_W'($urandom_range(1, 32'h7FFF_FFFF));
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_item(CMD_LOOKUP, 31'd5);
		send_item(CMD_DELETE, 31'd5);
		send_item(CMD_UNUSED, 31'd0);
		// inserts at the ends, key zero, two that shift into the middle, and a duplicate
		send_item(CMD_INSERT, 31'h7FFF_FFFF);
		send_item(CMD_INSERT, 31'd1);
		send_item(CMD_INSERT, 31'd0);
		send_item(CMD_INSERT, 31'h4000_0000);
		send_item(CMD_INSERT, 31'h2AAA_AAAA);
		send_item(CMD_INSERT, 31'd1);
		send_item(CMD_LOOKUP, 31'd1);
		send_item(CMD_LOOKUP, 31'd0);
		send_item(CMD_LOOKUP, 31'h5555_5555);
		// logical delete, repeat delete, lookup and re-insert of a deleted key, unused-code lookups, delete of an absent key
		send_item(CMD_DELETE, 31'h7FFF_FFFF);
		send_item(CMD_DELETE, 31'h7FFF_FFFF);
		send_item(CMD_LOOKUP, 31'h7FFF_FFFF);
		send_item(CMD_INSERT, 31'h7FFF_FFFF);
		send_item(CMD_UNUSED, 31'h4000_0000);
		send_item(CMD_UNUSED, 31'h7FFF_FFFF);
		send_item(CMD_DELETE, 31'd2);
		send_item(CMD_LOOKUP, 31'h2AAA_AAAA);

		random_phase(pool);

		tx_idle_pct = 57;
		rx_idle_pct <= 19;
		random_phase(pool);

		// no idling; the receiver stalls long enough for the block to back up
		tx_idle_pct = 0;
		rx_idle_pct <= 0;
		hold_asked <= hold_asked + 1;
		random_phase(pool);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("summary: %0d commands sent, %0d results checked", sent, checked);
		$display("summary: ok %0d, not found %0d, duplicate %0d, full %0d", ok_seen,
			miss_seen, dup_seen, full_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("sorted_index_table: match");
		end else begin
			$display("sorted_index_table: mismatch");
		end
		$finish;
	end

endmodule
